// File: sv/upc_pkg.sv
// Package for the URL percent codec: command and beat types, character
// constants and the small character helper functions. Depends on nothing.
`default_nettype none

package upc_pkg;

   // Character constants
   localparam logic [7:0] CHAR_PERCENT = 8'h25;   // '%'
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;   // '+'
   localparam logic [7:0] CHAR_SPACE   = 8'h20;   // ' '
   localparam logic [7:0] CHAR_ZERO    = 8'h30;   // '0'
   localparam logic [7:0] CHAR_NINE    = 8'h39;   // '9'
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;   // 'A'
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;   // 'Z'
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;   // 'a'
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;   // 'z'
   localparam logic [7:0] HEX_TEN      = 8'd10;

   // Mode register values
   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   // Command queue between the front and back ends
   localparam int CMD_FIFO_DEPTH = 4;
   localparam int CMD_PTR_W      = $clog2(CMD_FIFO_DEPTH);
   localparam int CMD_CNT_W      = $clog2(CMD_FIFO_DEPTH + 1);

   // Beat position within an escape triple
   localparam int BEAT_IDX_W = 2;
   localparam logic [BEAT_IDX_W-1:0] BEAT_PERCENT = 2'd0;
   localparam logic [BEAT_IDX_W-1:0] BEAT_HIGH    = 2'd1;
   localparam logic [BEAT_IDX_W-1:0] BEAT_LOW     = 2'd2;

   typedef enum logic [1:0] {
      ESC_IDLE   = 2'd0,
      ESC_FIRST  = 2'd1,
      ESC_SECOND = 2'd2
   } esc_phase_type;

   typedef enum logic [1:0] {
      CMD_PASS   = 2'd0,
      CMD_ESCAPE = 2'd1,
      CMD_ERROR  = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   data;
      logic         msg_last;
   } cmd_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       run_last;
      logic       msg_end;
      logic       error;
   } rsp_beat_type;

   function automatic logic is_alnum(input logic [7:0] c);
      return ((c >= CHAR_ZERO) && (c <= CHAR_NINE)) ||
             ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) ||
             ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z));
   endfunction

   // Value of a hex digit, unchecked: anything outside '0'..'9' is taken as
   // an uppercase letter digit, wrapping modulo 256.
   function automatic logic [7:0] digit_value(input logic [7:0] c);
      logic [7:0] v;
      if ((c >= CHAR_ZERO) && (c <= CHAR_NINE)) begin
         v = c - CHAR_ZERO;
      end else begin
         v = c - CHAR_UPPER_A + HEX_TEN;
      end
      return v;
   endfunction

   // Uppercase hex character for a nibble.
   function automatic logic [7:0] hex_char(input logic [3:0] n);
      logic [7:0] v;
      v = {4'd0, n};
      if (v > 8'd9) begin
         v = v - HEX_TEN + CHAR_UPPER_A;
      end else begin
         v = v + CHAR_ZERO;
      end
      return v;
   endfunction

endpackage

`default_nettype wire

// File: sv/upc_intf.sv
// Handshake interfaces for the request (text byte) and response (result
// beat) channels of the URL percent codec. No dependencies.
`default_nettype none

interface upc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       msg_last;

   modport source (output valid, output in_byte, output msg_last, input ready);
   modport sink   (input valid, input in_byte, input msg_last, output ready);
endinterface

interface upc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       run_last;
   logic       msg_end;
   logic       error;

   modport source (output valid, output out_byte, output byte_valid, output run_last,
                   output msg_end, output error, input ready);
   modport sink   (input valid, input out_byte, input byte_valid, input run_last,
                   input msg_end, input error, output ready);
endinterface

`default_nettype wire

// File: sv/upc_front.sv
// Front end of the URL percent codec: holds the mode register and escape state,
// classifies each beat and pushes a command per byte or error. Uses upc_pkg.
`default_nettype none

module upc_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic             csr_wr_data,
   upc_req_if.sink          req_if,
   input  logic             queue_full,
   output logic             push_valid,
   output upc_pkg::cmd_type push_cmd
);
   import upc_pkg::*;

   logic          mode_ff, mode_in;
   esc_phase_type phase_ff, phase_in;
   logic [3:0]    nibble_ff, nibble_in;
   logic          accept;
   logic [7:0]    c;
   logic [7:0]    dv;

   assign req_if.ready = !queue_full;
   assign accept       = req_if.valid && !queue_full;
   assign c            = req_if.in_byte;
   assign dv           = digit_value(c);
   assign mode_in      = csr_wr_en ? csr_wr_data : mode_ff;

   always_comb begin
      phase_in          = phase_ff;
      nibble_in         = nibble_ff;
      push_valid        = 1'b0;
      push_cmd.kind     = CMD_PASS;
      push_cmd.data     = c;
      push_cmd.msg_last = req_if.msg_last;
      if (accept) begin
         if (mode_ff == MODE_ENCODE) begin
            phase_in      = ESC_IDLE;
            push_valid    = 1'b1;
            push_cmd.kind = is_alnum(c) ? CMD_PASS : CMD_ESCAPE;
         end else begin
            case (phase_ff)
               ESC_FIRST: begin
                  nibble_in = dv[3:0];
                  phase_in  = ESC_SECOND;
                  if (req_if.msg_last) begin
                     phase_in      = ESC_IDLE;
                     push_valid    = 1'b1;
                     push_cmd.kind = CMD_ERROR;
                  end
               end
               ESC_SECOND: begin
                  phase_in      = ESC_IDLE;
                  push_valid    = 1'b1;
                  push_cmd.data = {nibble_ff, 4'd0} | dv;
               end
               default: begin
                  phase_in = ESC_IDLE;
                  if (c == CHAR_PERCENT) begin
                     phase_in = ESC_FIRST;
                     if (req_if.msg_last) begin
                        phase_in      = ESC_IDLE;
                        push_valid    = 1'b1;
                        push_cmd.kind = CMD_ERROR;
                     end
                  end else begin
                     push_valid    = 1'b1;
                     push_cmd.data = (c == CHAR_PLUS) ? CHAR_SPACE : c;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_ENCODE;
         phase_ff  <= ESC_IDLE;
         nibble_ff <= 4'd0;
      end else begin
         mode_ff   <= mode_in;
         phase_ff  <= phase_in;
         nibble_ff <= nibble_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/upc_cmd_fifo.sv
// Short command queue between the front and back ends of the URL percent
// codec. Uses upc_pkg for the command type and depth.
`default_nettype none

module upc_cmd_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  upc_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output upc_pkg::cmd_type head_cmd
);
   import upc_pkg::*;

   cmd_type                entry_ff [CMD_FIFO_DEPTH];
   logic [CMD_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0]   count_ff, count_in;
   logic                   do_push, do_pop;

   assign full       = (count_ff == CMD_CNT_W'(CMD_FIFO_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == CMD_PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0
                                                                   : wr_ptr_ff + CMD_PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == CMD_PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0
                                                                   : rd_ptr_ff + CMD_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CMD_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CMD_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// File: sv/upc_back.sv
// Back end of the URL percent codec: expands each queued command into one
// or three response beats through a registered output stage. Uses upc_pkg.
`default_nettype none

module upc_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  upc_pkg::cmd_type head_cmd,
   output logic             pop,
   upc_rsp_if.source        rsp_if
);
   import upc_pkg::*;

   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_beat_type          beat_ff;
   rsp_beat_type          beat_in;
   logic [BEAT_IDX_W-1:0] beat_idx_ff, beat_idx_in;
   logic                  load;
   logic                  last_beat;

   assign load      = head_valid && (!rsp_valid_ff || rsp_if.ready);
   assign last_beat = (head_cmd.kind != CMD_ESCAPE) || (beat_idx_ff == BEAT_LOW);
   assign pop       = load && last_beat;

   always_comb begin
      beat_in = '0;
      case (head_cmd.kind)
         CMD_PASS: begin
            beat_in.out_byte   = head_cmd.data;
            beat_in.byte_valid = 1'b1;
            beat_in.run_last   = 1'b1;
            beat_in.msg_end    = head_cmd.msg_last;
         end
         CMD_ESCAPE: begin
            beat_in.byte_valid = 1'b1;
            case (beat_idx_ff)
               BEAT_PERCENT: beat_in.out_byte = CHAR_PERCENT;
               BEAT_HIGH:    beat_in.out_byte = hex_char(head_cmd.data[7:4]);
               default: begin
                  beat_in.out_byte = hex_char(head_cmd.data[3:0]);
                  beat_in.run_last = 1'b1;
                  beat_in.msg_end  = head_cmd.msg_last;
               end
            endcase
         end
         CMD_ERROR: begin
            beat_in.run_last = 1'b1;
            beat_in.msg_end  = 1'b1;
            beat_in.error    = 1'b1;
         end
         default: beat_in = '0;
      endcase
   end

   always_comb begin
      beat_idx_in = beat_idx_ff;
      if (load) begin
         beat_idx_in = last_beat ? BEAT_PERCENT : beat_idx_ff + BEAT_IDX_W'(1);
      end
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         beat_idx_ff  <= BEAT_PERCENT;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         beat_idx_ff  <= beat_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         beat_ff <= beat_in;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.out_byte   = beat_ff.out_byte;
   assign rsp_if.byte_valid = beat_ff.byte_valid;
   assign rsp_if.run_last   = beat_ff.run_last;
   assign rsp_if.msg_end    = beat_ff.msg_end;
   assign rsp_if.error      = beat_ff.error;

endmodule

`default_nettype wire

// File: sv/url_percent_codec_top.sv
// Top level of the URL percent codec: front end, command queue and back end.
// Depends on upc_pkg, upc_intf, upc_front, upc_cmd_fifo and upc_back.
//
//   Channel   Direction  Beat contents
//   req_if    in         in_byte, msg_last
//   rsp_if    out        out_byte, byte_valid, run_last, msg_end, error
//   csr_*     in         mode bit (0 encode, 1 decode), write enable and data
//
// The front end takes one request beat per cycle as long as the four-entry
// command queue has room; once the queue is full, req_if.ready drops until
// the back end pops a command.
// The back end sends one response beat per cycle while rsp_if is ready; an
// encoded escape needs three beats, so the sustained rate is set by the
// single response port.
// With an empty queue, a request beat's command is written into the queue
// and then loaded into the output register before its response is presented.
// The response beat sits in an output register, so a stall on rsp_if does not
// stop the queue from being filled. Reset is synchronous and clears the mode,
// the escape state, the queue and the output valid flag.
`default_nettype none

module url_percent_codec_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   upc_req_if.sink    req_if,
   upc_rsp_if.source  rsp_if
);
   import upc_pkg::*;

   // Commands leave the front end already classified: a plain byte, an
   // escape triple to be expanded, or a bare error.
   logic    push_valid;
   cmd_type push_cmd;
   logic    queue_full;
   logic    pop;
   logic    head_valid;
   cmd_type head_cmd;

   upc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_if      (req_if),
      .queue_full  (queue_full),
      .push_valid  (push_valid),
      .push_cmd    (push_cmd)
   );

   // The queue lets the front end keep accepting while the back end is busy
   // spelling out an escape or waiting on a stalled response.
   upc_cmd_fifo u_cmd_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   upc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_if     (rsp_if)
   );

endmodule

`default_nettype wire
